### design/sdfd_pkg.sv
// ----------------------------------------------------------------------------
// sdfd_pkg: shared types and constants of the decimal fraction divider
// Transaction payloads, per-cell control word and power-of-ten lookup.
// ----------------------------------------------------------------------------
package sdfd_pkg;

   localparam int OPND_WIDTH   = 32;
   localparam int QUOT_WIDTH   = 52;
   localparam int DIGITS_WIDTH = 3;
   localparam int POW_WIDTH    = 20;
   localparam int NUM_EXTRA    = 20;

   localparam logic [DIGITS_WIDTH-1:0] DIGITS_RESET = 3'd2;

   typedef struct packed {
      logic signed [OPND_WIDTH-1:0] dividend;
      logic signed [OPND_WIDTH-1:0] divisor;
   } sdfd_req_type;

   typedef struct packed {
      logic signed [QUOT_WIDTH-1:0] scaled_quotient;
      logic                         divide_error;
   } sdfd_rsp_type;

   typedef struct packed {
      logic valid;
      logic negate;
      logic zero_div;
   } sdfd_ctl_type;

   function automatic logic [POW_WIDTH-1:0] pow10(input logic [DIGITS_WIDTH-1:0] digits);
      logic [POW_WIDTH-1:0] value;
      case (digits)
         3'd0: value = 20'd1;
         3'd1: value = 20'd10;
         3'd2: value = 20'd100;
         3'd3: value = 20'd1000;
         3'd4: value = 20'd10000;
         3'd5: value = 20'd100000;
         3'd6: value = 20'd1000000;
         default: value = 20'd1000000;
      endcase
      return value;
   endfunction

endpackage

### design/sdfd_cell.sv
// ----------------------------------------------------------------------------
// sdfd_cell: one restoring-division step
// Shifts in one numerator bit, trial-subtracts the divisor and passes the
// partial remainder, remaining numerator and quotient to the next cell.
// ----------------------------------------------------------------------------
module sdfd_cell #(
   parameter int DIV_WIDTH = 32,
   parameter int NUM_WIDTH = 52
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sdfd_pkg::sdfd_ctl_type up_ctl,
   input  logic [DIV_WIDTH-1:0]   up_rem,
   input  logic [NUM_WIDTH-1:0]   up_num,
   input  logic [NUM_WIDTH-1:0]   up_quo,
   input  logic [DIV_WIDTH-1:0]   up_div,
   output sdfd_pkg::sdfd_ctl_type dn_ctl,
   output logic [DIV_WIDTH-1:0]   dn_rem,
   output logic [NUM_WIDTH-1:0]   dn_num,
   output logic [NUM_WIDTH-1:0]   dn_quo,
   output logic [DIV_WIDTH-1:0]   dn_div
);
   import sdfd_pkg::*;

   sdfd_ctl_type         ctl_ff, ctl_in;
   logic [DIV_WIDTH-1:0] rem_ff, rem_in;
   logic [NUM_WIDTH-1:0] num_ff, num_in;
   logic [NUM_WIDTH-1:0] quo_ff, quo_in;
   logic [DIV_WIDTH-1:0] div_ff;
   logic [DIV_WIDTH:0]   trial;
   logic [DIV_WIDTH:0]   diff;
   logic                 fits;

   always_comb begin
      trial  = {up_rem, up_num[NUM_WIDTH-1]};
      diff   = trial - {1'b0, up_div};
      fits   = trial >= {1'b0, up_div};
      rem_in = fits ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
      num_in = {up_num[NUM_WIDTH-2:0], 1'b0};
      quo_in = {up_quo[NUM_WIDTH-2:0], fits};
      ctl_in = up_ctl;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      div_ff <= up_div;
   end

   assign dn_ctl = ctl_ff;
   assign dn_rem = rem_ff;
   assign dn_num = num_ff;
   assign dn_quo = quo_ff;
   assign dn_div = div_ff;

endmodule

### design/sdfd_array.sv
// ----------------------------------------------------------------------------
// sdfd_array: row of division cells
// Chains one cell per quotient bit; a transaction advances one cell a cycle.
// ----------------------------------------------------------------------------
module sdfd_array #(
   parameter int DIV_WIDTH = 32,
   parameter int NUM_WIDTH = 52
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sdfd_pkg::sdfd_ctl_type head_ctl,
   input  logic [NUM_WIDTH-1:0]   head_num,
   input  logic [DIV_WIDTH-1:0]   head_div,
   output sdfd_pkg::sdfd_ctl_type tail_ctl,
   output logic [NUM_WIDTH-1:0]   tail_quo
);
   import sdfd_pkg::*;

   sdfd_ctl_type         ctl [0:NUM_WIDTH];
   logic [DIV_WIDTH-1:0] rem [0:NUM_WIDTH];
   logic [NUM_WIDTH-1:0] num [0:NUM_WIDTH];
   logic [NUM_WIDTH-1:0] quo [0:NUM_WIDTH];
   logic [DIV_WIDTH-1:0] dvs [0:NUM_WIDTH];

   assign ctl[0] = head_ctl;
   assign rem[0] = '0;
   assign num[0] = head_num;
   assign quo[0] = '0;
   assign dvs[0] = head_div;

   for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_cell
      sdfd_cell #(
         .DIV_WIDTH(DIV_WIDTH),
         .NUM_WIDTH(NUM_WIDTH)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_ctl (ctl[i]),
         .up_rem (rem[i]),
         .up_num (num[i]),
         .up_quo (quo[i]),
         .up_div (dvs[i]),
         .dn_ctl (ctl[i+1]),
         .dn_rem (rem[i+1]),
         .dn_num (num[i+1]),
         .dn_quo (quo[i+1]),
         .dn_div (dvs[i+1])
      );
   end

   assign tail_ctl = ctl[NUM_WIDTH];
   assign tail_quo = quo[NUM_WIDTH];

endmodule

### design/signed_decimal_fraction_divider_core.sv
// ----------------------------------------------------------------------------
// signed_decimal_fraction_divider_core: signed divide to decimal places
// Returns sign * floor(|dividend| * 10^digits / |divisor|); a zero divisor
// flags an error and returns zero.
//
//   channel  ports                          direction  handshake
//   request  start, busy, req_data          in         start && !busy
//   response rsp_valid, rsp_data            out        one-cycle strobe
//   csr      csr_valid, csr_ready, csr_data in         csr_valid && csr_ready
//
// One transaction at a time. An accepted transaction passes the operand and
// scaling stages, the row of DATA_WIDTH + 20 division cells and the output
// stage, in that order, before rsp_valid rises.
// busy drops in the cycle rsp_valid is shown, so a new transaction can be
// accepted at the edge that ends the response. The receiver cannot stall.
// Synchronous reset returns fraction_digits to 2 and drops any transaction.
// ----------------------------------------------------------------------------
module signed_decimal_fraction_divider_core #(
   parameter int DATA_WIDTH          = 32,
   parameter int MAX_FRACTION_DIGITS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  sdfd_pkg::sdfd_req_type req_data,
   output logic                   rsp_valid,
   output sdfd_pkg::sdfd_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [sdfd_pkg::DIGITS_WIDTH-1:0] csr_data
);
   import sdfd_pkg::*;

   localparam int NUM_WIDTH = DATA_WIDTH + NUM_EXTRA;
   localparam logic [DIGITS_WIDTH-1:0] MAX_DIGITS = DIGITS_WIDTH'(MAX_FRACTION_DIGITS);

   logic [DIGITS_WIDTH-1:0] digits_ff, digits_in;
   logic                    busy_ff, busy_in;
   logic                    accept;

   logic [DATA_WIDTH-1:0] opn, opd;
   logic [DATA_WIDTH-1:0] mag_n, mag_d;
   logic [DIGITS_WIDTH-1:0] digits_sat;

   sdfd_ctl_type          op_ctl_ff, op_ctl_in;
   logic [DATA_WIDTH-1:0] mag_n_ff, mag_d_ff;
   logic [POW_WIDTH-1:0]  pow_ff;

   sdfd_ctl_type          num_ctl_ff, num_ctl_in;
   logic [NUM_WIDTH-1:0]  num_ff, num_in;
   logic [DATA_WIDTH-1:0] div_ff;

   sdfd_ctl_type          tail_ctl;
   logic [NUM_WIDTH-1:0]  tail_quo;

   logic                  rsp_valid_ff;
   sdfd_rsp_type          rsp_ff, rsp_in;
   logic [QUOT_WIDTH-1:0] quo_ext;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      digits_in = digits_ff;
      if (csr_valid && csr_ready) begin
         digits_in = csr_data;
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (tail_ctl.valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      opn        = req_data.dividend[DATA_WIDTH-1:0];
      opd        = req_data.divisor[DATA_WIDTH-1:0];
      mag_n      = opn[DATA_WIDTH-1] ? (~opn + 1'b1) : opn;
      mag_d      = opd[DATA_WIDTH-1] ? (~opd + 1'b1) : opd;
      digits_sat = (digits_ff > MAX_DIGITS) ? MAX_DIGITS : digits_ff;
      op_ctl_in.valid    = accept;
      op_ctl_in.negate   = opn[DATA_WIDTH-1] ^ opd[DATA_WIDTH-1];
      op_ctl_in.zero_div = (opd == '0);
   end

   always_comb begin
      num_in     = NUM_WIDTH'(mag_n_ff) * NUM_WIDTH'(pow_ff);
      num_ctl_in = op_ctl_ff;
   end

   always_comb begin
      quo_ext = QUOT_WIDTH'(tail_quo);
      if (tail_ctl.zero_div) begin
         rsp_in.scaled_quotient = '0;
      end else if (tail_ctl.negate) begin
         rsp_in.scaled_quotient = -quo_ext;
      end else begin
         rsp_in.scaled_quotient = quo_ext;
      end
      rsp_in.divide_error = tail_ctl.zero_div;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_ff    <= DIGITS_RESET;
         busy_ff      <= 1'b0;
         op_ctl_ff    <= '0;
         num_ctl_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         digits_ff    <= digits_in;
         busy_ff      <= busy_in;
         op_ctl_ff    <= op_ctl_in;
         num_ctl_ff   <= num_ctl_in;
         rsp_valid_ff <= tail_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mag_n_ff <= mag_n;
         mag_d_ff <= mag_d;
         pow_ff   <= pow10(digits_sat);
      end
      num_ff <= num_in;
      div_ff <= mag_d_ff;
      if (tail_ctl.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   sdfd_array #(
      .DIV_WIDTH(DATA_WIDTH),
      .NUM_WIDTH(NUM_WIDTH)
   ) u_array (
      .clock    (clock),
      .reset    (reset),
      .head_ctl (num_ctl_ff),
      .head_num (num_ff),
      .head_div (div_ff),
      .tail_ctl (tail_ctl),
      .tail_quo (tail_quo)
   );

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response shown while busy");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_error) |-> (rsp_data.scaled_quotient == '0))
      else $error("divide error with nonzero quotient");

   a_single_flight: assert property (@(posedge clock) disable iff (reset)
      $onehot0({op_ctl_ff.valid, num_ctl_ff.valid, rsp_valid_ff}))
      else $error("more than one transaction in flight");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (op_ctl_ff.valid || num_ctl_ff.valid) |-> busy)
      else $error("transaction in flight while not busy");

endmodule
